[hdl/drpr_pkg.sv]
// Shared types, constants and the arctangent helper function of the pose reporter.
`default_nettype none
package drpr_pkg;

    // report format
    localparam int DIGITS   = 4;
    localparam int NBYTES   = 2 * DIGITS + 2;
    localparam int SAT_MAX  = 10 ** DIGITS - 1;
    localparam int VW       = $clog2(SAT_MAX + 1);
    localparam int DCW      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int FCW      = $clog2(NBYTES + 1);

    // divide by ten through a reciprocal multiply
    localparam logic [31:0] DIV10_M  = 32'hCCCC_CCCD;
    localparam int          DIV10_SH = 35;

    // rotation unit
    localparam int CORDIC_STEPS = 14;
    localparam int CPC          = 3;
    localparam int ITW          = 5;
    localparam int XW           = 19;
    localparam logic signed [XW-1:0] CORDIC_X0 = 19'sd19898;

    // command codes, also the drive order on the result port
    localparam logic [2:0] CMD_FWD   = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_BWD   = 3'd2;
    localparam logic [2:0] CMD_RIGHT = 3'd3;
    localparam logic [2:0] CMD_LEFT  = 3'd4;

    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // configuration
    localparam int CFG_IW = 8;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] REG_STEP_DIST = 8'd0;
    localparam logic [CFG_IW-1:0] REG_TURN_STEP = 8'd1;
    localparam logic [15:0] STEP_DIST_RST = 16'd1638;
    localparam logic [14:0] TURN_STEP_RST = 15'd5664;

    // state reset values
    localparam logic [15:0] HEADING_RST = 16'd49152;
    localparam logic [31:0] POS_X_RST   = 32'd61440;
    localparam logic [31:0] POS_Y_RST   = 32'd76800;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [15:0] heading;
        logic [2:0]  cmd;
    } t_cmd_ent;

    typedef struct packed {
        logic [VW-1:0] vx;
        logic [VW-1:0] vy;
        logic [2:0]    drive;
    } t_rpt;

    function automatic logic signed [XW-1:0] atan_at(input logic [ITW-1:0] i);
        logic signed [XW-1:0] a;
        case (i)
            5'd0:    a = 19'sd8192;
            5'd1:    a = 19'sd4836;
            5'd2:    a = 19'sd2555;
            5'd3:    a = 19'sd1297;
            5'd4:    a = 19'sd651;
            5'd5:    a = 19'sd326;
            5'd6:    a = 19'sd163;
            5'd7:    a = 19'sd81;
            5'd8:    a = 19'sd41;
            5'd9:    a = 19'sd20;
            5'd10:   a = 19'sd10;
            5'd11:   a = 19'sd5;
            5'd12:   a = 19'sd3;
            5'd13:   a = 19'sd1;
            default: a = 19'sd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

[hdl/dead_reckoning_pose_reporter.sv]
// Top level: dead-reckoning pose reporter, one ten-byte report per poll tick.
// The sustained tick rate is set by the ten result pops of each report.
// The front takes a tick per cycle, while the queue is not full, into a
// 4-entry queue; the motion unit steps IDLE, ROT (the 3-step/cycle CORDIC),
// MUL, ADD and SEND for a driving tick, and IDLE and SEND otherwise.
// Reset (synchronous, active low) restores pose, command and registers.
`default_nettype none
module dead_reckoning_pose_reporter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output      logic                          o_full,
    input  wire logic                          i_rx_valid,
    input  wire logic [7:0]                    i_rx_byte,
    output      logic                          o_empty,
    input  wire logic                          i_pop,
    output      logic [7:0]                    o_out_byte,
    output      logic                          o_last_byte,
    output      logic [2:0]                    o_drive,
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [drpr_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [drpr_pkg::CFG_DW-1:0]   i_cfg_data
);

    logic [15:0]          r_step_dist;
    logic [14:0]          r_turn_step;

    logic                 q_push, q_pop, q_valid;
    drpr_pkg::t_cmd_ent   q_in, q_out;
    logic                 rpt_valid, rpt_ready;
    drpr_pkg::t_rpt       rpt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_dist <= drpr_pkg::STEP_DIST_RST;
            r_turn_step <= drpr_pkg::TURN_STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                drpr_pkg::REG_STEP_DIST: r_step_dist <= i_cfg_data;
                drpr_pkg::REG_TURN_STEP: r_turn_step <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    drpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .i_turn_step (r_turn_step),
        .i_q_full    (o_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    drpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    drpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step_dist (r_step_dist),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .o_rpt_valid (rpt_valid),
        .i_rpt_ready (rpt_ready),
        .o_rpt       (rpt)
    );

    drpr_report u_report (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rpt_valid (rpt_valid),
        .o_rpt_ready (rpt_ready),
        .i_rpt       (rpt),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .o_drive     (o_drive)
    );

endmodule
`default_nettype wire

[hdl/drpr_front.sv]
// Front end: takes poll ticks, turns the heading and latches the command.
`default_nettype none
module drpr_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic                  i_rx_valid,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic [14:0]           i_turn_step,
    input  wire logic                  i_q_full,
    output      logic                  o_q_push,
    output      drpr_pkg::t_cmd_ent    o_q_data
);

    logic [15:0] r_heading, n_heading;
    logic [2:0]  r_cmd, n_cmd;
    logic        accept;

    assign accept = i_push && !i_q_full;

    always_comb begin
        n_heading = r_heading;
        if (r_cmd == drpr_pkg::CMD_RIGHT) begin
            n_heading = r_heading + {1'b0, i_turn_step};
        end else if (r_cmd == drpr_pkg::CMD_LEFT) begin
            n_heading = r_heading - {1'b0, i_turn_step};
        end
        n_cmd = r_cmd;
        if (i_rx_valid) begin
            case (i_rx_byte)
                drpr_pkg::CH_F: n_cmd = drpr_pkg::CMD_FWD;
                drpr_pkg::CH_S: n_cmd = drpr_pkg::CMD_STOP;
                drpr_pkg::CH_B: n_cmd = drpr_pkg::CMD_BWD;
                drpr_pkg::CH_R: n_cmd = drpr_pkg::CMD_RIGHT;
                drpr_pkg::CH_L: n_cmd = drpr_pkg::CMD_LEFT;
                default:        n_cmd = r_cmd;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= drpr_pkg::HEADING_RST;
            r_cmd     <= drpr_pkg::CMD_STOP;
        end else if (accept) begin
            r_heading <= n_heading;
            r_cmd     <= n_cmd;
        end
    end

    assign o_q_push         = accept;
    assign o_q_data.heading = n_heading;
    assign o_q_data.cmd     = n_cmd;

endmodule
`default_nettype wire

[hdl/drpr_queue.sv]
// Short command queue between the front end and the motion unit.
`default_nettype none
module drpr_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire drpr_pkg::t_cmd_ent i_data,
    output      logic               o_full,
    input  wire logic               i_pop,
    output      logic               o_valid,
    output      drpr_pkg::t_cmd_ent o_data
);

    drpr_pkg::t_cmd_ent              r_mem [drpr_pkg::QDEPTH];
    logic [drpr_pkg::QAW-1:0]        r_wp, r_rp;
    logic [drpr_pkg::QCW-1:0]        r_cnt;
    logic                            do_push, do_pop;

    assign o_full  = (r_cnt == drpr_pkg::QCW'(drpr_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!do_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

[hdl/drpr_back.sv]
// Motion unit: sin/cos by iterative CORDIC, position update, range clamp.
`default_nettype none
module drpr_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [15:0]        i_step_dist,
    input  wire logic               i_q_valid,
    input  wire drpr_pkg::t_cmd_ent i_q_data,
    output      logic               o_q_pop,
    output      logic               o_rpt_valid,
    input  wire logic               i_rpt_ready,
    output      drpr_pkg::t_rpt     o_rpt
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROT  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_SEND = 3'd4;
    localparam int XW = drpr_pkg::XW;

    logic [2:0]                 r_state;
    logic [drpr_pkg::ITW-1:0]   r_it;
    logic signed [XW-1:0]       r_x, r_y, r_z;
    logic                       r_neg;
    logic [2:0]                 r_drive;
    logic signed [32:0]         r_px, r_py;
    logic [31:0]                r_pos_x, r_pos_y;

    logic signed [XW-1:0]       cx [drpr_pkg::CPC+1];
    logic signed [XW-1:0]       cy [drpr_pkg::CPC+1];
    logic signed [XW-1:0]       cz [drpr_pkg::CPC+1];
    logic [drpr_pkg::ITW-1:0]   idx [drpr_pkg::CPC];
    logic [drpr_pkg::ITW-1:0]   it_next;

    logic [15:0]                h_dir, h_red;
    logic                       red_neg, moving;
    logic signed [XW-1:0]       xf, yf;
    logic signed [15:0]         cval, sval;
    logic signed [33:0]         sum_x, sum_y;

    // angle reduction: fold the left half plane onto the right one
    always_comb begin
        h_dir   = (i_q_data.cmd == drpr_pkg::CMD_BWD) ? (i_q_data.heading ^ 16'h8000)
                                                      : i_q_data.heading;
        red_neg = h_dir[15] ^ h_dir[14];
        h_red   = red_neg ? (h_dir ^ 16'h8000) : h_dir;
        moving  = (i_q_data.cmd == drpr_pkg::CMD_FWD) || (i_q_data.cmd == drpr_pkg::CMD_BWD);
    end

    // CPC micro-rotations per cycle
    always_comb begin
        cx[0] = r_x;
        cy[0] = r_y;
        cz[0] = r_z;
        for (int j = 0; j < drpr_pkg::CPC; j++) begin
            idx[j] = r_it + drpr_pkg::ITW'(j);
            if (idx[j] < drpr_pkg::ITW'(drpr_pkg::CORDIC_STEPS)) begin
                if (!cz[j][XW-1]) begin
                    cx[j+1] = cx[j] - (cy[j] >>> idx[j]);
                    cy[j+1] = cy[j] + (cx[j] >>> idx[j]);
                    cz[j+1] = cz[j] - drpr_pkg::atan_at(idx[j]);
                end else begin
                    cx[j+1] = cx[j] + (cy[j] >>> idx[j]);
                    cy[j+1] = cy[j] - (cx[j] >>> idx[j]);
                    cz[j+1] = cz[j] + drpr_pkg::atan_at(idx[j]);
                end
            end else begin
                cx[j+1] = cx[j];
                cy[j+1] = cy[j];
                cz[j+1] = cz[j];
            end
        end
        it_next = r_it + drpr_pkg::ITW'(drpr_pkg::CPC);
    end

    // sign fix and Q1.15 clamp
    always_comb begin
        xf = r_neg ? -r_x : r_x;
        yf = r_neg ? -r_y : r_y;
        if (xf > 19'sd32767) begin
            cval = 16'sd32767;
        end else if (xf < -19'sd32767) begin
            cval = -16'sd32767;
        end else begin
            cval = xf[15:0];
        end
        if (yf > 19'sd32767) begin
            sval = 16'sd32767;
        end else if (yf < -19'sd32767) begin
            sval = -16'sd32767;
        end else begin
            sval = yf[15:0];
        end
        sum_x = 34'(r_px) + 34'sd16384;
        sum_y = 34'(r_py) + 34'sd16384;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos_x <= drpr_pkg::POS_X_RST;
            r_pos_y <= drpr_pkg::POS_Y_RST;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= moving ? ST_ROT : ST_SEND;
                    end
                end
                ST_ROT: begin
                    if (it_next >= drpr_pkg::ITW'(drpr_pkg::CORDIC_STEPS)) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_pos_x <= r_pos_x + 32'(sum_x >>> 15);
                    r_pos_y <= r_pos_y + 32'(sum_y >>> 15);
                    r_state <= ST_SEND;
                end
                ST_SEND: begin
                    if (i_rpt_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x     <= drpr_pkg::CORDIC_X0;
                r_y     <= '0;
                r_z     <= XW'($signed(h_red));
                r_neg   <= red_neg;
                r_it    <= '0;
                r_drive <= i_q_data.cmd;
            end
            ST_ROT: begin
                r_x  <= cx[drpr_pkg::CPC];
                r_y  <= cy[drpr_pkg::CPC];
                r_z  <= cz[drpr_pkg::CPC];
                r_it <= it_next;
            end
            ST_MUL: begin
                r_px <= 33'($signed({1'b0, i_step_dist})) * 33'(cval);
                r_py <= 33'($signed({1'b0, i_step_dist})) * 33'(sval);
            end
            default: begin
            end
        endcase
    end

    // ceil(pos/256), clamped to the printable range
    function automatic logic [drpr_pkg::VW-1:0] sat_mm(input logic [31:0] pos);
        logic signed [32:0] t;
        logic signed [32:0] v;
        t = $signed({pos[31], pos}) + 33'sd255;
        v = t >>> 8;
        if (v < 33'sd0) begin
            return '0;
        end else if (v > 33'(drpr_pkg::SAT_MAX)) begin
            return drpr_pkg::VW'(drpr_pkg::SAT_MAX);
        end
        return v[drpr_pkg::VW-1:0];
    endfunction

    assign o_q_pop      = (r_state == ST_IDLE) && i_q_valid;
    assign o_rpt_valid  = (r_state == ST_SEND);
    assign o_rpt.vx     = sat_mm(r_pos_x);
    assign o_rpt.vy     = sat_mm(r_pos_y);
    assign o_rpt.drive  = r_drive;

endmodule
`default_nettype wire

[hdl/drpr_report.sv]
// Report builder: decimal conversion and the outgoing byte frame.
`default_nettype none
module drpr_report (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_rpt_valid,
    output      logic           o_rpt_ready,
    input  wire drpr_pkg::t_rpt i_rpt,
    input  wire logic           i_pop,
    output      logic           o_empty,
    output      logic [7:0]     o_out_byte,
    output      logic           o_last_byte,
    output      logic [2:0]     o_drive
);

    localparam int VW = drpr_pkg::VW;
    localparam int NB = drpr_pkg::NBYTES;
    localparam int DG = drpr_pkg::DIGITS;

    logic                       r_busy, r_done;
    logic [drpr_pkg::DCW-1:0]   r_dcnt;
    logic [VW-1:0]              r_vx, r_vy;
    logic [2:0]                 r_drive;
    logic [3:0]                 r_digx [DG];
    logic [3:0]                 r_digy [DG];

    logic [7:0]                 r_frame [NB];
    logic [drpr_pkg::FCW-1:0]   r_fcnt;
    logic [2:0]                 r_fdrive;

    logic [VW+31:0]             mx, my;
    logic [VW-1:0]              qx, qy, remx, remy;
    logic [drpr_pkg::DCW-1:0]   dpos;
    logic                       take, pop_ok, load;

    // one digit per cycle: q = v/10 by reciprocal, digit = v - 10q
    always_comb begin
        mx   = (VW+32)'(r_vx) * (VW+32)'(drpr_pkg::DIV10_M);
        my   = (VW+32)'(r_vy) * (VW+32)'(drpr_pkg::DIV10_M);
        qx   = VW'(mx >> drpr_pkg::DIV10_SH);
        qy   = VW'(my >> drpr_pkg::DIV10_SH);
        remx = r_vx - VW'({qx, 3'b000}) - VW'({qx, 1'b0});
        remy = r_vy - VW'({qy, 3'b000}) - VW'({qy, 1'b0});
        dpos = drpr_pkg::DCW'(DG - 1) - r_dcnt;
    end

    // the next report may start as soon as the finished digits move to the frame
    assign o_rpt_ready = !r_busy && (!r_done || load);
    assign take        = i_rpt_valid && o_rpt_ready;
    assign pop_ok      = i_pop && (r_fcnt != '0);
    assign load        = r_done && ((r_fcnt == '0) ||
                                    ((r_fcnt == drpr_pkg::FCW'(1)) && i_pop));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_dcnt <= '0;
            r_fcnt <= '0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
                r_dcnt <= '0;
            end else if (r_busy) begin
                if (r_dcnt == drpr_pkg::DCW'(DG - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_dcnt <= r_dcnt + 1'b1;
                end
            end
            if (load) begin
                r_done <= 1'b0;
                r_fcnt <= drpr_pkg::FCW'(NB);
            end else if (pop_ok) begin
                r_fcnt <= r_fcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_vx    <= i_rpt.vx;
            r_vy    <= i_rpt.vy;
            r_drive <= i_rpt.drive;
        end else if (r_busy) begin
            r_vx         <= qx;
            r_vy         <= qy;
            r_digx[dpos] <= remx[3:0];
            r_digy[dpos] <= remy[3:0];
        end
        if (load) begin
            for (int i = 0; i < DG; i++) begin
                r_frame[i]        <= drpr_pkg::CH_ZERO + {4'b0000, r_digx[i]};
                r_frame[DG+1+i]   <= drpr_pkg::CH_ZERO + {4'b0000, r_digy[i]};
            end
            r_frame[DG]   <= drpr_pkg::CH_COMMA;
            r_frame[NB-1] <= drpr_pkg::CH_NUL;
            r_fdrive      <= r_drive;
        end else if (pop_ok) begin
            for (int i = 0; i < NB - 1; i++) begin
                r_frame[i] <= r_frame[i+1];
            end
        end
    end

    assign o_empty     = (r_fcnt == '0);
    assign o_out_byte  = r_frame[0];
    assign o_last_byte = (r_fcnt == drpr_pkg::FCW'(1));
    assign o_drive     = r_fdrive;

endmodule
`default_nettype wire

[hdl/drpr_checker.sv]
// Port-level checks on the report stream of the pose reporter.
`default_nettype none
module drpr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_pop,
    input wire logic       i_empty,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_last_byte,
    input wire logic [2:0] i_drive
);

    // nothing to pop straight after reset
    a_empty_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> i_empty)
        else $error("result queue not empty after reset");

    // a report never breaks off before its terminating beat
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_pop && !i_last_byte) |=> !i_empty)
        else $error("report interrupted mid-frame");

    // drive order is the same across one report
    a_drive_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_pop && !i_last_byte) |=> (i_drive == $past(i_drive)))
        else $error("drive changed inside a report");

    a_last_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_last_byte) |-> (i_out_byte == 8'h00))
        else $error("terminating beat is not a zero byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> (!i_empty && $stable(i_out_byte) &&
                                  $stable(i_last_byte) && $stable(i_drive)))
        else $error("waiting result changed before it was taken");

endmodule

bind dead_reckoning_pose_reporter drpr_checker u_drpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pop       (i_pop),
    .i_empty     (o_empty),
    .i_out_byte  (o_out_byte),
    .i_last_byte (o_last_byte),
    .i_drive     (o_drive)
);
`default_nettype wire

[dv/dead_reckoning_pose_reporter_tb.sv]
// Self-checking testbench for the dead-reckoning pose reporter.
module dead_reckoning_pose_reporter_tb;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_TICKS  = 90;
    localparam logic [15:0] HALF_TURN    = 16'h8000;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic [2:0] drive;
    } t_report_beat;

    class pose_scoreboard;
        logic [15:0]  step_dist;
        logic [14:0]  turn_step;
        logic [15:0]  heading;
        logic [31:0]  pos_x;
        logic [31:0]  pos_y;
        logic [2:0]   cmd;
        t_report_beat report_q[$];
        int           errors;
        longint       atan_lut[drpr_pkg::CORDIC_STEPS];

        function new();
            step_dist = drpr_pkg::STEP_DIST_RST;
            turn_step = drpr_pkg::TURN_STEP_RST;
            heading   = drpr_pkg::HEADING_RST;
            pos_x     = drpr_pkg::POS_X_RST;
            pos_y     = drpr_pkg::POS_Y_RST;
            cmd       = drpr_pkg::CMD_STOP;
            errors    = 0;
            atan_lut  = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        endfunction

        task report_mismatch(input string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        function void set_reg(input logic [drpr_pkg::CFG_IW-1:0] idx,
                              input logic [drpr_pkg::CFG_DW-1:0] val);
            if (idx == drpr_pkg::REG_STEP_DIST)
                step_dist = val;
            else if (idx == drpr_pkg::REG_TURN_STEP)
                turn_step = val[14:0];
        endfunction

        function longint clamp_q15(input longint v);
            if (v > 32767)
                return 32767;
            if (v < -32767)
                return -32767;
            return v;
        endfunction

        // 14-step rotation, angle folded into the right half-plane first
        function void sin_cos(input logic [15:0] ang, output longint c, output longint s);
            longint      x, y, z, nx;
            logic [15:0] a;
            bit          flip;
            int          i;
            x    = drpr_pkg::CORDIC_X0;
            y    = 0;
            a    = ang;
            flip = 0;
            if (a >= 16'd16384 && a < 16'd49152) begin
                a    = a - HALF_TURN;
                flip = 1;
            end
            z = longint'($signed(a));
            for (i = 0; i < drpr_pkg::CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - atan_lut[i];
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + atan_lut[i];
                end
                x = nx;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            c = clamp_q15(x);
            s = clamp_q15(y);
        endfunction

        function logic [31:0] moved(input logic [31:0] pos, input longint comp);
            longint d;
            d = (longint'(step_dist) * comp + 16384) >>> 15;
            return pos + d[31:0];
        endfunction

        function void push_beat(input logic [7:0] ch, input logic last);
            t_report_beat b;
            b.ch    = ch;
            b.last  = last;
            b.drive = cmd;
            report_q.push_back(b);
        endfunction

        function void push_number(input logic [31:0] pos);
            longint     v;
            logic [7:0] dig[drpr_pkg::DIGITS];
            int         i;
            v = (longint'($signed(pos)) + 255) >>> 8;
            if (v < 0)
                v = 0;
            if (v > drpr_pkg::SAT_MAX)
                v = drpr_pkg::SAT_MAX;
            for (i = drpr_pkg::DIGITS - 1; i >= 0; i--) begin
                dig[i] = drpr_pkg::CH_ZERO + 8'(v % 10);
                v      = v / 10;
            end
            for (i = 0; i < drpr_pkg::DIGITS; i++)
                push_beat(dig[i], 1'b0);
        endfunction

        function void note_tick(input logic v, input logic [7:0] b);
            logic [15:0] h;
            longint      c, s;
            if (cmd == drpr_pkg::CMD_RIGHT)
                heading = heading + {1'b0, turn_step};
            else if (cmd == drpr_pkg::CMD_LEFT)
                heading = heading - {1'b0, turn_step};
            if (v) begin
                case (b)
                    drpr_pkg::CH_F: cmd = drpr_pkg::CMD_FWD;
                    drpr_pkg::CH_S: cmd = drpr_pkg::CMD_STOP;
                    drpr_pkg::CH_B: cmd = drpr_pkg::CMD_BWD;
                    drpr_pkg::CH_R: cmd = drpr_pkg::CMD_RIGHT;
                    drpr_pkg::CH_L: cmd = drpr_pkg::CMD_LEFT;
                    default: ;
                endcase
            end
            if (cmd == drpr_pkg::CMD_FWD || cmd == drpr_pkg::CMD_BWD) begin
                h = heading;
                if (cmd == drpr_pkg::CMD_BWD)
                    h = h + HALF_TURN;
                sin_cos(h, c, s);
                pos_x = moved(pos_x, c);
                pos_y = moved(pos_y, s);
            end
            push_number(pos_x);
            push_beat(drpr_pkg::CH_COMMA, 1'b0);
            push_number(pos_y);
            push_beat(drpr_pkg::CH_NUL, 1'b1);
        endfunction

        task check_beat(input logic [7:0] ch, input logic last, input logic [2:0] drv);
            t_report_beat e;
            if (report_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat byte=%02h last=%0b drive=%0d",
                                          ch, last, drv));
            end else begin
                e = report_q.pop_front();
                if (ch !== e.ch)
                    report_mismatch($sformatf("out_byte %02h, want %02h", ch, e.ch));
                if (last !== e.last)
                    report_mismatch($sformatf("last_byte %0b, want %0b", last, e.last));
                if (drv !== e.drive)
                    report_mismatch($sformatf("drive %0d, want %0d", drv, e.drive));
            end
        endtask
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_push;
    logic                        o_full;
    logic                        i_rx_valid;
    logic [7:0]                  i_rx_byte;
    logic                        o_empty;
    logic                        i_pop;
    logic [7:0]                  o_out_byte;
    logic                        o_last_byte;
    logic [2:0]                  o_drive;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [drpr_pkg::CFG_IW-1:0] i_cfg_index;
    logic [drpr_pkg::CFG_DW-1:0] i_cfg_data;

    pose_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    bit             hold_req;
    int             hold_left;
    int             cycles;

    dead_reckoning_pose_reporter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .o_drive     (o_drive),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check popped beats, then decide whether to pop next cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty)
                sb.check_beat(o_out_byte, o_last_byte, o_drive);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 61 : (mode == IDLE_BOTH) ? 33 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 61 : (mode == IDLE_BOTH) ? 33 : 0;
    endtask

    // push stays high after the beat so back-to-back ticks need no re-raise
    task automatic send_tick(input logic v, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push     <= 1'b1;
        i_rx_valid <= v;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_full);
        sb.note_tick(v, b);
    endtask

    task automatic write_reg(input logic [drpr_pkg::CFG_IW-1:0] idx,
                             input logic [drpr_pkg::CFG_DW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_push <= 1'b0;
        while (sb.report_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly real commands, some junk bytes and empty ticks
    task automatic random_tick();
        int          r;
        logic [7:0]  b;
        r = $urandom_range(99);
        b = 8'($urandom_range(255));
        if (r < 65) begin
            case ($urandom_range(5))
                0, 1: b = drpr_pkg::CH_F;
                2: b = drpr_pkg::CH_B;
                3: b = drpr_pkg::CH_R;
                4: b = drpr_pkg::CH_L;
                default: b = drpr_pkg::CH_S;
            endcase
            send_tick(1'b1, b);
        end else begin
            send_tick(r < 82, b);
        end
    endtask

    initial begin
        logic [15:0] step_set[5];
        logic [15:0] turn_set[5];
        int          p, n;
        sb             = new();
        cycles         = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        i_rst_n        = 1'b0;
        i_push         = 1'b0;
        i_rx_valid     = 1'b0;
        i_rx_byte      = 8'h00;
        i_pop          = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        set_idling(IDLE_NONE);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // long steps from the reset heading: y runs below zero, then past the top
        write_reg(drpr_pkg::REG_STEP_DIST, 16'hFFFF);
        repeat (3) send_tick(1'b1, drpr_pkg::CH_F);
        send_tick(1'b1, drpr_pkg::CH_B);
        repeat (45) send_tick(1'b0, 8'($urandom_range(255)));
        settle();
        write_reg(drpr_pkg::REG_STEP_DIST, drpr_pkg::STEP_DIST_RST);

        send_tick(1'b0, 8'h00);
        send_tick(1'b0, drpr_pkg::CH_F);
        repeat (2) send_tick(1'b1, drpr_pkg::CH_F);
        repeat (2) send_tick(1'b1, drpr_pkg::CH_R);
        send_tick(1'b1, drpr_pkg::CH_F);
        repeat (3) send_tick(1'b1, drpr_pkg::CH_L);
        repeat (2) send_tick(1'b1, drpr_pkg::CH_B);
        send_tick(1'b1, 8'h66);
        send_tick(1'b1, 8'hFF);
        send_tick(1'b1, 8'h00);
        send_tick(1'b1, drpr_pkg::CH_R);
        send_tick(1'b1, drpr_pkg::CH_S);
        send_tick(1'b0, 8'hFF);
        settle();

        step_set = '{16'd0, 16'd1, 16'($urandom_range(65535)), 16'hFFFF,
                     drpr_pkg::STEP_DIST_RST};
        turn_set = '{16'd0, 16'hFFFF, 16'($urandom_range(65535)), 16'd1,
                     16'(drpr_pkg::TURN_STEP_RST)};
        for (p = 0; p < 5; p++) begin
            write_reg(drpr_pkg::REG_STEP_DIST, step_set[p]);
            write_reg(drpr_pkg::REG_TURN_STEP, turn_set[p]);
            if (p == 2) begin
                // indexes with no register behind them
                write_reg(8'd2, 16'h1234);
                write_reg(8'hFF, 16'hFFFF);
            end
            set_idling(t_idle_mode'(p % 4));
            if (p == 0)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_TICKS; n++)
                random_tick();
            settle();
        end

        if (sb.report_q.size() != 0)
            sb.report_mismatch($sformatf("%0d beats never arrived", sb.report_q.size()));
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
